FILE: hw/rtl/pws_pkg.sv
// Shared types and constants for the PID controller with slew limit and settle detection.
package pws_pkg;

   // Q8.8 feedforward gain on the setpoint
   localparam logic signed [15:0] FEEDFORWARD_GAIN = 16'sd0;

   // Register indexes on the configuration port
   localparam logic [2:0] REG_KP       = 3'd0;
   localparam logic [2:0] REG_KI       = 3'd1;
   localparam logic [2:0] REG_KD       = 3'd2;
   localparam logic [2:0] REG_WINDOW   = 3'd3;
   localparam logic [2:0] REG_SLEW     = 3'd4;
   localparam logic [2:0] REG_BAND     = 3'd5;
   localparam logic [2:0] REG_HOLD     = 3'd6;
   localparam logic [2:0] REG_TIMEOUT  = 3'd7;

   localparam int CSR_DATA_W = 31;

   // Settle cause codes
   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
   localparam logic [1:0] CAUSE_BAND    = 2'd2;

   typedef struct packed {
      logic signed [15:0] setpoint;
      logic signed [15:0] measured;
      logic        [31:0] now_ms;
      logic               restart;
   } pws_item_type;

   typedef struct packed {
      logic signed [15:0] kp;
      logic signed [15:0] ki;
      logic signed [15:0] kd;
      logic        [16:0] window;
      logic        [30:0] slew;
      logic        [16:0] band;
      logic        [15:0] hold_ms;
      logic        [15:0] timeout_ms;
   } pws_cfg_type;

   typedef struct packed {
      logic       settled;
      logic [1:0] cause;
   } pws_settle_type;

endpackage

FILE: hw/rtl/pws_loop.sv
// PID datapath: error, gain products, floor and saturation, slew clamp, integral update.
module pws_loop (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  pws_pkg::pws_item_type item,
   input  pws_pkg::pws_cfg_type  cfg,
   output logic signed [31:0]    drive,
   output logic        [16:0]    err_mag
);
   import pws_pkg::*;

   logic signed [16:0] last_error_ff, last_error_in;
   logic signed [31:0] error_sum_ff, error_sum_in;
   logic signed [31:0] last_drive_ff, last_drive_in;

   logic signed [16:0] le, err;
   logic signed [31:0] sum_prev, sum_base, ld;
   logic signed [17:0] derr;
   logic signed [32:0] p_prod;
   logic signed [47:0] i_prod;
   logic signed [33:0] d_prod;
   logic signed [31:0] f_prod;
   logic signed [49:0] acc;
   logic signed [41:0] quo;
   logic signed [31:0] pwr_sat;
   logic signed [32:0] pwr33, hi, lo, slew33, pwr_slew;
   logic signed [32:0] sum_wide;
   logic signed [31:0] sum_sat;
   logic               sign_flip;

   // restart clears loop state ahead of this step
   assign le       = item.restart ? 17'sd0 : last_error_ff;
   assign sum_prev = item.restart ? 32'sd0 : error_sum_ff;
   assign ld       = item.restart ? 32'sd0 : last_drive_ff;

   assign err  = {item.setpoint[15], item.setpoint} - {item.measured[15], item.measured};
   assign derr = {err[16], err} - {le[16], le};

   assign sign_flip = (!le[16] && (le != 17'sd0) && err[16]) ||
                      (le[16] && !err[16] && (err != 17'sd0));
   assign sum_base  = sign_flip ? 32'sd0 : sum_prev;

   assign p_prod = cfg.kp * err;
   assign i_prod = cfg.ki * sum_base;
   assign d_prod = cfg.kd * derr;
   assign f_prod = FEEDFORWARD_GAIN * item.setpoint;

   assign acc = 50'(p_prod) + 50'(i_prod) + 50'(d_prod) + 50'(f_prod);
   // arithmetic shift floors toward minus infinity
   assign quo = acc[49:8];

   always_comb begin
      if ((&quo[41:31]) || !(|quo[41:31])) begin
         pwr_sat = quo[31:0];
      end else if (quo[41]) begin
         pwr_sat = 32'sh8000_0000;
      end else begin
         pwr_sat = 32'sh7fff_ffff;
      end
   end

   assign slew33 = {2'b00, cfg.slew};
   assign pwr33  = {pwr_sat[31], pwr_sat};
   assign hi     = {ld[31], ld} + slew33;
   assign lo     = {ld[31], ld} - slew33;

   always_comb begin
      pwr_slew = pwr33;
      if (cfg.slew != 31'd0) begin
         if (pwr33 > hi) begin
            pwr_slew = hi;
         end else if (pwr33 < lo) begin
            pwr_slew = lo;
         end
      end
   end

   assign drive   = pwr_slew[31:0];
   assign err_mag = err[16] ? 17'(-err) : err;

   assign sum_wide = {sum_base[31], sum_base} + 33'(err);

   always_comb begin
      if (sum_wide[32] == sum_wide[31]) begin
         sum_sat = sum_wide[31:0];
      end else if (sum_wide[32]) begin
         sum_sat = 32'sh8000_0000;
      end else begin
         sum_sat = 32'sh7fff_ffff;
      end
   end

   assign last_error_in = err;
   assign last_drive_in = drive;
   assign error_sum_in  = (err_mag < cfg.window) ? sum_sat : sum_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_error_ff <= '0;
         error_sum_ff  <= '0;
         last_drive_ff <= '0;
      end else if (step_en) begin
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
         last_drive_ff <= last_drive_in;
      end
   end

endmodule

FILE: hw/rtl/pws_settle.sv
// Settle detection: overall timeout timer and error-band hold timer.
module pws_settle (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  logic                   restart,
   input  logic [31:0]            now_ms,
   input  logic [16:0]            err_mag,
   input  pws_pkg::pws_cfg_type   cfg,
   output pws_pkg::pws_settle_type status
);
   import pws_pkg::*;

   logic [31:0] start_time_ff, start_time_in;
   logic        start_valid_ff, start_valid_in;
   logic [31:0] hold_time_ff, hold_time_in;
   logic        hold_valid_ff, hold_valid_in;

   logic [31:0] st, ht;
   logic        sv, hv;

   assign st = restart ? 32'd0 : start_time_ff;
   assign sv = restart ? 1'b0  : start_valid_ff;
   assign ht = restart ? 32'd0 : hold_time_ff;
   assign hv = restart ? 1'b0  : hold_valid_ff;

   always_comb begin
      start_time_in  = st;
      start_valid_in = sv;
      hold_time_in   = ht;
      hold_valid_in  = hv;
      status.settled = 1'b0;
      status.cause   = CAUSE_NONE;

      if (cfg.timeout_ms != 16'd0) begin
         if (!sv) begin
            start_time_in  = now_ms;
            start_valid_in = 1'b1;
         end else if ((now_ms - st) > {16'd0, cfg.timeout_ms}) begin
            status.settled = 1'b1;
            status.cause   = CAUSE_TIMEOUT;
         end
      end

      // band check skipped once the timeout has fired
      if (!status.settled && (cfg.band != 17'd0)) begin
         if (err_mag >= cfg.band) begin
            hold_valid_in = 1'b0;
         end else if (!hv) begin
            hold_time_in  = now_ms;
            hold_valid_in = 1'b1;
         end else if ((now_ms - ht) > {16'd0, cfg.hold_ms}) begin
            status.settled = 1'b1;
            status.cause   = CAUSE_BAND;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff  <= '0;
         start_valid_ff <= 1'b0;
         hold_time_ff   <= '0;
         hold_valid_ff  <= 1'b0;
      end else if (step_en) begin
         start_time_ff  <= start_time_in;
         start_valid_ff <= start_valid_in;
         hold_time_ff   <= hold_time_in;
         hold_valid_ff  <= hold_valid_in;
      end
   end

endmodule

FILE: hw/rtl/pid_with_slew_and_settle_top.sv
// Top level of the PID controller with slew limit and settle detection.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   req     | in        | req_valid/req_stall| setpoint, measured, now_ms, restart
//   rsp     | out       | rsp_valid/rsp_stall| drive, is_settled, settle_cause
//   csr     | in        | csr_we             | csr_index, csr_wdata
//
// One item per cycle sustained while the output is free; an accepted item moves
// from the input register to the result register and shows on rsp. The rate is
// set by the combinational loop update: the gain products, sum and clamps all sit
// between the input and result registers, so loop state is ready for the next item.
// Synchronous active-high reset clears loop state, timers, config and valids.
// req_stall rises only when both the input register and a stalled result are full.
module pid_with_slew_and_settle_top (
   input  logic                              clock,
   input  logic                              reset,
   // control step input
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [15:0]                req_setpoint,
   input  logic signed [15:0]                req_measured,
   input  logic        [31:0]                req_now_ms,
   input  logic                              req_restart,
   // step result
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_drive,
   output logic                              rsp_is_settled,
   output logic        [1:0]                 rsp_settle_cause,
   // configuration writes
   input  logic                              csr_we,
   input  logic        [2:0]                 csr_index,
   input  logic        [pws_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pws_pkg::*;

   pws_cfg_type    cfg_ff;
   pws_item_type   item_ff;
   logic           item_valid_ff, item_valid_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] drive_ff;
   pws_settle_type status_ff;

   logic               advance, req_take;
   logic signed [31:0] drive;
   logic        [16:0] err_mag;
   pws_settle_type     status;

   // held item moves into the result register when that register is free
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.setpoint <= req_setpoint;
         item_ff.measured <= req_measured;
         item_ff.now_ms   <= req_now_ms;
         item_ff.restart  <= req_restart;
      end
      if (advance) begin
         drive_ff  <= drive;
         status_ff <= status;
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_KP:      cfg_ff.kp         <= csr_wdata[15:0];
            REG_KI:      cfg_ff.ki         <= csr_wdata[15:0];
            REG_KD:      cfg_ff.kd         <= csr_wdata[15:0];
            REG_WINDOW:  cfg_ff.window     <= csr_wdata[16:0];
            REG_SLEW:    cfg_ff.slew       <= csr_wdata[30:0];
            REG_BAND:    cfg_ff.band       <= csr_wdata[16:0];
            REG_HOLD:    cfg_ff.hold_ms    <= csr_wdata[15:0];
            REG_TIMEOUT: cfg_ff.timeout_ms <= csr_wdata[15:0];
            default:     cfg_ff            <= cfg_ff;
         endcase
      end
   end

   pws_loop u_loop (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg_ff),
      .drive   (drive),
      .err_mag (err_mag)
   );

   pws_settle u_settle (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .restart (item_ff.restart),
      .now_ms  (item_ff.now_ms),
      .err_mag (err_mag),
      .cfg     (cfg_ff),
      .status  (status)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive        = drive_ff;
   assign rsp_is_settled   = status_ff.settled;
   assign rsp_settle_cause = status_ff.cause;

endmodule

FILE: hw/rtl/pws_checker.sv
// Port-level assertions for the PID controller top, bound to it.
module pws_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic signed [31:0]                rsp_drive,
   input logic                              rsp_is_settled,
   input logic        [1:0]                 rsp_settle_cause
);
   import pws_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_drive) &&
      $stable(rsp_is_settled) && $stable(rsp_settle_cause))
      else $error("stalled result changed");

   // settled flag and cause agree
   a_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_settled ?
         (rsp_settle_cause == CAUSE_TIMEOUT || rsp_settle_cause == CAUSE_BAND) :
         (rsp_settle_cause == CAUSE_NONE)))
      else $error("settle cause mismatch");

   // input never blocked while the output is empty
   a_no_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled with empty output");

   // an accepted item passes the input and result registers to the output if not stalled
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted item did not appear");

   // nothing valid right after reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind pid_with_slew_and_settle_top pws_checker u_pws_checker (.*);
